// ----- rtl/dhct_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dhct_pkg
// Shared types and constants of the detection hit count tracker: the input
// and result words, the table entry, the settings and the sequencer states.
// ----------------------------------------------------------------------------
package dhct_pkg;

    localparam int ID_COUNT  = 32;
    localparam int IDX_W     = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam int ID_W      = 5;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 8;

    localparam logic KIND_DET = 1'b0;
    localparam logic KIND_EOF = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_INC_WEIGHT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DEC_WEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = CFG_IDX_W'(3);

    localparam logic [CNT_W-1:0] INC_WEIGHT_RST = CNT_W'(1);
    localparam logic [CNT_W-1:0] DEC_WEIGHT_RST = CNT_W'(1);
    localparam logic [CNT_W-1:0] MAX_COUNT_RST  = CNT_W'(10);
    localparam logic [CNT_W-1:0] THRESHOLD_RST  = CNT_W'(5);

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] marker_id;
        logic            point_found;
    } t_in_word;

    typedef struct packed {
        logic             report_valid;
        logic [ID_W-1:0]  report_id;
        logic [CNT_W-1:0] report_count;
        logic             last;
    } t_out_word;

    typedef struct packed {
        logic             present;
        logic [CNT_W-1:0] count;
        logic             seen;
        logic             pos_found;
    } t_entry;

    typedef struct packed {
        logic [CNT_W-1:0] inc_weight;
        logic [CNT_W-1:0] dec_weight;
        logic [CNT_W-1:0] max_count;
        logic [CNT_W-1:0] threshold;
    } t_cfg;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_tbl_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DET_UPD,
        ST_EOF_RD,
        ST_EOF_EV,
        ST_EOF_FLUSH
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/dhct_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dhct_table
// Marker table: one synchronous memory with a registered read port and a
// written flag per entry, so that an entry never written reads as zero.
// ----------------------------------------------------------------------------
module dhct_table
    import dhct_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_tbl_req i_req,
    output t_entry        o_rd_data
);

    t_entry              r_mem [ID_COUNT];
    t_entry              r_rd_data;
    logic [ID_COUNT-1:0] r_written;
    logic                r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_written[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_written <= r_written[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_data : '0;

endmodule

`default_nettype wire

// ----- rtl/dhct_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dhct_ctrl
// Sequencer: read-modify-write of one entry per detection, table walk at
// end of frame, one held-back report to mark the last word, output register.
// ----------------------------------------------------------------------------
module dhct_ctrl
    import dhct_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_data,
    output t_tbl_req       o_tbl_req,
    input  wire t_entry    i_rd_data
);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_det_id;
    logic             r_det_pt;
    t_out_word        r_pend;
    logic             r_pend_vld;
    t_out_word        r_out;
    logic             r_out_vld;

    logic             in_acc;
    logic             id_ok;
    logic             slot_free;
    logic             qualify;
    logic             last_idx;
    logic             stall;
    logic [CNT_W-1:0] det_base;
    logic [CNT_W:0]   det_sum;
    logic [CNT_W-1:0] det_cnt;
    t_entry           det_entry;
    t_entry           eof_entry;
    t_out_word        cur_report;
    logic             push;
    t_out_word        push_word;
    logic             pend_load;
    logic             pend_clear;
    logic             idx_step;

    assign in_acc    = i_in_valid && o_in_ready;
    assign id_ok     = int'(i_in_data.marker_id) < ID_COUNT;
    assign slot_free = !r_out_vld || i_out_ready;
    assign last_idx  = int'(r_idx) == ID_COUNT - 1;

    // detection update
    always_comb begin
        det_base            = i_rd_data.present ? i_rd_data.count : '0;
        det_sum             = {1'b0, det_base} + {1'b0, i_cfg.inc_weight};
        det_cnt             = (det_sum > {1'b0, i_cfg.max_count}) ? i_cfg.max_count
                                                                  : det_sum[CNT_W-1:0];
        det_entry.present   = 1'b1;
        det_entry.count     = det_cnt;
        det_entry.seen      = 1'b1;
        det_entry.pos_found = r_det_pt;
    end

    // end of frame aging and report check
    always_comb begin
        eof_entry      = i_rd_data;
        eof_entry.seen = 1'b0;
        if (i_rd_data.present && !i_rd_data.seen) begin
            eof_entry.pos_found = 1'b0;
            if (i_rd_data.count <= i_cfg.dec_weight) begin
                eof_entry.present = 1'b0;
                eof_entry.count   = '0;
            end else begin
                eof_entry.count = i_rd_data.count - i_cfg.dec_weight;
            end
        end
        qualify = i_rd_data.present && i_rd_data.seen && i_rd_data.pos_found &&
                  (i_rd_data.count >= i_cfg.threshold);
        cur_report.report_valid = 1'b1;
        cur_report.report_id    = ID_W'(r_idx);
        cur_report.report_count = i_rd_data.count;
        cur_report.last         = 1'b0;
    end

    assign stall = qualify && r_pend_vld && !slot_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.kind == KIND_EOF) begin
                        n_state = ST_EOF_RD;
                    end else if (id_ok) begin
                        n_state = ST_DET_UPD;
                    end
                end
            end
            ST_DET_UPD: n_state = ST_IDLE;
            ST_EOF_RD:  n_state = ST_EOF_EV;
            ST_EOF_EV: begin
                if (!stall) begin
                    n_state = last_idx ? ST_EOF_FLUSH : ST_EOF_RD;
                end
            end
            ST_EOF_FLUSH: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_tbl_req.rd_en   = 1'b0;
        o_tbl_req.rd_addr = r_idx;
        o_tbl_req.wr_en   = 1'b0;
        o_tbl_req.wr_addr = r_idx;
        o_tbl_req.wr_data = eof_entry;
        push              = 1'b0;
        push_word         = r_pend;
        pend_load         = 1'b0;
        pend_clear        = 1'b0;
        idx_step          = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_tbl_req.rd_en   = i_in_valid && (i_in_data.kind == KIND_DET) && id_ok;
                o_tbl_req.rd_addr = IDX_W'(i_in_data.marker_id);
            end
            ST_DET_UPD: begin
                o_tbl_req.wr_en   = 1'b1;
                o_tbl_req.wr_addr = r_det_id;
                o_tbl_req.wr_data = det_entry;
            end
            ST_EOF_RD: begin
                o_tbl_req.rd_en = 1'b1;
            end
            ST_EOF_EV: begin
                if (!stall) begin
                    o_tbl_req.wr_en = 1'b1;
                    push            = qualify && r_pend_vld;
                    pend_load       = qualify;
                    idx_step        = !last_idx;
                end
            end
            ST_EOF_FLUSH: begin
                if (slot_free) begin
                    push       = 1'b1;
                    pend_clear = 1'b1;
                    if (r_pend_vld) begin
                        push_word.last = 1'b1;
                    end else begin
                        push_word = '{report_valid: 1'b0, report_id: '0,
                                      report_count: '0, last: 1'b1};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state <= n_state;
            if (pend_load) begin
                r_pend_vld <= 1'b1;
            end else if (pend_clear) begin
                r_pend_vld <= 1'b0;
            end
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (in_acc) begin
                r_idx <= '0;
            end else if (idx_step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_det_id <= IDX_W'(i_in_data.marker_id);
            r_det_pt <= i_in_data.point_found;
        end
        if (pend_load) begin
            r_pend <= cur_report;
        end
        if (push) begin
            r_out <= push_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- rtl/detection_hit_count_tracker_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// detection_hit_count_tracker_top
// Confirmation filter for marker detections. A detection word is handled as
// one table read, then one write back; an end-of-frame word walks the table,
// reading and evaluating each entry, then flushes; output back-pressure can
// hold the walk. A word is finished before the next is taken. Reports of one
// frame come out in rising id order, the final one with last set; a frame
// with nothing confirmed gives one word with report_valid low and last set.
// Settings are written by index: 0 increment, 1 decrement, 2 maximum count,
// 3 publish threshold; other indexes are ignored. Write them only when idle.
// ----------------------------------------------------------------------------
module detection_hit_count_tracker_top
    import dhct_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_word             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_word                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg     r_cfg;
    t_tbl_req tbl_req;
    t_entry   tbl_rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inc_weight <= INC_WEIGHT_RST;
            r_cfg.dec_weight <= DEC_WEIGHT_RST;
            r_cfg.max_count  <= MAX_COUNT_RST;
            r_cfg.threshold  <= THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INC_WEIGHT: r_cfg.inc_weight <= i_cfg_data;
                CFG_DEC_WEIGHT: r_cfg.dec_weight <= i_cfg_data;
                CFG_MAX_COUNT:  r_cfg.max_count  <= i_cfg_data;
                CFG_THRESHOLD:  r_cfg.threshold  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dhct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_tbl_req   (tbl_req),
        .i_rd_data   (tbl_rd_data)
    );

    dhct_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .o_rd_data (tbl_rd_data)
    );

endmodule

`default_nettype wire
